### design/mbpc_pkg.sv
// Shared constants and helpers for the multi-base palindrome checker.
// Used by the digit cell, the base lane and the top level.
package mbpc_pkg;

    localparam int NumWidth   = 32;
    localparam int MaxDigits  = 32;
    localparam int FirstBase  = 2;
    localparam int NumBases   = 15;
    localparam int DigitWidth = 4;
    localparam int CountWidth = $clog2(MaxDigits + 1);
    localparam int IdxWidth   = $clog2(MaxDigits);

    typedef logic [NumWidth-1:0]   num_t;
    typedef logic [DigitWidth-1:0] digit_t;
    typedef logic [CountWidth-1:0] count_t;
    typedef logic [NumBases-1:0]   mask_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_COMPARE,
        ST_DONE
    } lane_state_t;

    // Lane control from the top level.
    typedef struct packed {
        logic start;
        logic release_res;
    } lane_ctrl_t;

endpackage

### design/mbpc_digit_cell.sv
// One digit stage of a base lane: holds a digit and shifts it on.
// Depends on mbpc_pkg.
module mbpc_digit_cell (
    input  logic            clk,
    input  logic            shift,
    input  mbpc_pkg::digit_t digit_in,
    output mbpc_pkg::digit_t digit_out
);
    import mbpc_pkg::*;

    digit_t digit_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            digit_reg <= digit_in;
        end
    end

    assign digit_out = digit_reg;
endmodule

### design/mbpc_base_lane.sv
// One base lane: restoring division emits each digit into a chain of
// digit cells, then a compare walks the chain. Depends on mbpc_pkg and
// mbpc_digit_cell.
module mbpc_base_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [4:0]          base,
    input  mbpc_pkg::lane_ctrl_t ctrl,
    input  mbpc_pkg::num_t      number,
    output logic                done,
    output logic                is_pal
);
    import mbpc_pkg::*;

    // Quotient bits resolved per divide cycle.
    localparam int DivChunk = 8;
    localparam int DivSteps = NumWidth / DivChunk;
    localparam int StepW    = $clog2(DivSteps + 1);

    lane_state_t state_reg, state_next;
    num_t        quot_reg, quot_next;
    logic [4:0]  rem_reg, rem_next;
    logic [StepW-1:0] bit_reg, bit_next;
    count_t      count_reg, count_next;
    count_t      lo_reg, lo_next;
    count_t      hi_reg, hi_next;
    logic        pal_reg, pal_next;
    logic        shift;
    digit_t      chain [MaxDigits+1];

    assign chain[0] = rem_reg[DigitWidth-1:0];

    // Digits enter at cell 0; the first digit ends farthest along the chain.
    for (genvar i = 0; i < MaxDigits; i++)
    begin : g_cell
        mbpc_digit_cell u_cell (
            .clk      (clk),
            .shift    (shift),
            .digit_in (chain[i]),
            .digit_out(chain[i+1])
        );
    end

    logic [5:0] trial;
    logic       fits;
    logic [4:0] rem_work;
    num_t       quot_work;
    digit_t     dig_lo, dig_hi;

    always_comb
    begin
        trial      = '0;
        fits       = 1'b0;
        rem_work   = rem_reg;
        quot_work  = quot_reg;
        state_next = state_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        pal_next   = pal_reg;
        shift      = 1'b0;
        dig_lo     = chain[count_t'(lo_reg + 1'b1)];
        dig_hi     = chain[count_t'(hi_reg + 1'b1)];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    quot_next  = number;
                    rem_next   = '0;
                    bit_next   = '0;
                    count_next = '0;
                    pal_next   = 1'b1;
                    state_next = (number == '0) ? ST_DONE : ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (bit_reg == StepW'(DivSteps))
                begin
                    // Remainder is the next digit; push it into the chain.
                    shift      = 1'b1;
                    count_next = count_reg + 1'b1;
                    rem_next   = '0;
                    bit_next   = '0;
                    if (quot_reg == '0)
                    begin
                        lo_next    = '0;
                        hi_next    = count_reg;
                        state_next = ST_COMPARE;
                    end
                end
                else
                begin
                    for (int s = 0; s < DivChunk; s++)
                    begin
                        trial     = {rem_work, quot_work[NumWidth-1]};
                        fits      = trial >= {1'b0, base};
                        quot_work = {quot_work[NumWidth-2:0], fits};
                        rem_work  = fits ? 5'(trial - {1'b0, base}) : trial[4:0];
                    end
                    quot_next = quot_work;
                    rem_next  = rem_work;
                    bit_next  = bit_reg + 1'b1;
                end
            end
            ST_COMPARE:
            begin
                // Chain index i holds digit count-i; symmetric test anyway.
                if (lo_reg >= hi_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    if (dig_lo != dig_hi)
                    begin
                        pal_next = 1'b0;
                    end
                    lo_next = lo_reg + 1'b1;
                    hi_next = hi_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (ctrl.release_res)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        bit_reg   <= bit_next;
        count_reg <= count_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        pal_reg   <= pal_next;
    end

    assign done   = state_reg == ST_DONE;
    assign is_pal = pal_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start && state_reg != ST_IDLE |-> 1'b0)
        else $error("lane started while busy");
    a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
        done && !ctrl.release_res |=> done)
        else $error("lane left done without release");
    a_compare_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVIDE |-> count_reg <= count_t'(MaxDigits))
        else $error("digit count overflow");
endmodule

### design/multi_base_palindrome_check.sv
// Multi-base palindrome checker: input number, output palindrome mask per
// base 2..16. Instantiates one mbpc_base_lane per base; uses mbpc_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall, number) takes one number at a time.
//   Output channel (out_valid/out_stall, base_mask, none_found) gives one
//   result per number, bit k of base_mask set when the number reads the
//   same both ways in base k+2; none_found is set when the mask is zero.
//   Zero counts as a palindrome in every base.
// Lanes: all fifteen lanes run at once. Each digit in a lane takes four
//   divide steps of 8 quotient bits each and one step to push the digit.
//   The slowest lane (base 2) sets when the result is ready.
// Throughput: one number per result; the next number is taken the cycle
//   after the result register is loaded, while the result may still wait.
// Reset clears all control; no transfer is pending afterwards. in_stall is
//   high from an input transfer until its result is loaded; while the
//   receiver stalls, the result holds and a finished next result waits in
//   the lanes, keeping in_stall high.
module multi_base_palindrome_check (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [31:0]          number,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [14:0]          base_mask,
    output logic                 none_found
);
    import mbpc_pkg::*;

    logic       busy_reg;
    logic       out_valid_reg;
    mask_t      mask_reg;
    logic [NumBases-1:0] done_vec, pal_vec;
    logic       all_done, load_out;
    lane_ctrl_t ctrl;

    assign all_done    = &done_vec;
    assign load_out    = busy_reg && all_done && (!out_valid_reg || !out_stall);
    assign in_stall    = busy_reg;
    assign ctrl.start  = in_valid && !busy_reg;
    assign ctrl.release_res = load_out;

    for (genvar b = 0; b < NumBases; b++)
    begin : g_lane
        mbpc_base_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .base  (5'(b + FirstBase)),
            .ctrl  (ctrl),
            .number(number),
            .done  (done_vec[b]),
            .is_pal(pal_vec[b])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (load_out)
            begin
                busy_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            mask_reg <= pal_vec;
        end
    end

    assign out_valid  = out_valid_reg;
    assign base_mask  = mask_reg;
    assign none_found = mask_reg == '0;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(base_mask))
        else $error("stalled result changed");
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> busy_reg)
        else $error("result loaded with no number in work");
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> busy_reg)
        else $error("transfer not tracked");
endmodule

### verif/palindrome_checker.sv
// Checker for the multi-base palindrome block: watches both channels,
// predicts the base mask for each accepted number and compares results.
// Depends on mbpc_pkg for the number and mask types and the base constants.
module palindrome_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  mbpc_pkg::num_t       number,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  mbpc_pkg::mask_t      base_mask,
    input  logic                 none_found,
    output int                   fail_count,
    output int                   pending_count
);
    import mbpc_pkg::*;

    typedef struct packed {
        mask_t mask;
        logic  none;
    } verdict_t;

    verdict_t expected_verdicts[$];

    // Digit string of value in base, least significant first, tested for symmetry.
    function automatic logic reads_same(num_t value, int unsigned base);
        int unsigned digits[MaxDigits];
        int unsigned count;
        int unsigned lo;
        int unsigned hi;
        num_t rest;
        count = 0;
        rest = value;
        while (rest != 0 && count < MaxDigits)
        begin
            digits[count] = rest % base;
            rest = rest / base;
            count++;
        end
        if (count < 2)
            return 1'b1;
        lo = 0;
        hi = count - 1;
        while (lo < hi)
        begin
            if (digits[lo] != digits[hi])
                return 1'b0;
            lo++;
            hi--;
        end
        return 1'b1;
    endfunction

    function automatic verdict_t predict_verdict(num_t value);
        verdict_t v;
        v.mask = '0;
        for (int k = 0; k < NumBases; k++)
            v.mask[k] = reads_same(value, k + FirstBase);
        v.none = (v.mask == '0);
        return v;
    endfunction

    assign pending_count = expected_verdicts.size();

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_verdicts.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_verdicts.push_back(predict_verdict(number));
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result mask=%h none=%b", base_mask, none_found);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (want.mask !== base_mask || want.none !== none_found)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: mask exp %h got %h, none exp %b got %b",
                                     want.mask, base_mask, want.none, none_found);
                    end
                end
            end
        end
    end
endmodule

### verif/tb.sv
// Top of the multi-base palindrome testbench: clock, reset, number stimulus
// with random gaps and receiver stalls. Depends on the block and palindrome_checker.
module tb;
    import mbpc_pkg::*;

    localparam int NumRandom = 1500;
    localparam int IdleLimit = 20000;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    num_t  number;
    logic  out_valid;
    logic  out_stall;
    mask_t base_mask;
    logic  none_found;
    int    fail_count;
    int    pending_count;
    int    idle_cycles;
    logic  stim_done;

    multi_base_palindrome_check dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .number(number),
        .out_valid(out_valid), .out_stall(out_stall),
        .base_mask(base_mask), .none_found(none_found)
    );

    palindrome_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .number(number),
        .out_valid(out_valid), .out_stall(out_stall),
        .base_mask(base_mask), .none_found(none_found),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        number = '0;
        out_stall = 1'b0;
        stim_done = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 300);
        return $urandom_range(0, 3);
    endfunction

    function automatic num_t random_number();
        num_t v;
        int unsigned base;
        int unsigned len;
        int unsigned d[16];
        case ($urandom_range(0, 5))
            0: v = $urandom();
            1: v = $urandom_range(0, 255);
            2: v = $urandom() >> $urandom_range(0, 31);
            default:
            begin
                // build a palindrome in a random base; large ones wrap at 32 bits
                base = $urandom_range(2, 16);
                len = $urandom_range(1, 7);
                for (int i = 0; i < len; i++)
                    d[i] = $urandom_range(i == 0 ? 1 : 0, base - 1);
                v = 0;
                for (int i = 0; i < 2 * len - (len % 2); i++)
                    v = v * base + (i < len ? d[i] : d[2 * len - (len % 2) - 1 - i]);
            end
        endcase
        return v;
    endfunction

    // Drop valid only for a gap; the caller drops it before any pause.
    task automatic send_number(num_t value);
        int gap;
        gap = gap_length();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        number <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // Receiver stalls: phases of no stall alternate with random stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 3) == 0)
            out_stall <= ($urandom_range(0, 99) < 40);
        else if ($urandom_range(0, 99) == 0)
            out_stall <= 1'b1;
        else
            out_stall <= (out_stall && $urandom_range(0, 9) != 0) ? 1'b1 : 1'b0;
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        num_t directed[$];
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd15, 32'd16, 32'd17,
                     32'd255, 32'd256, 32'd585, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555,
                     32'h8000_0001, 32'd10, 32'd121, 32'd4};
        idle_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_number(directed[i]);
        // hold off until every result has drained
        drain();
        for (int i = 0; i < NumRandom; i++)
        begin
            send_number(random_number());
            if (i == NumRandom / 2)
            begin
                drain();
            end
        end
        drain();
        repeat (1200) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
